// ===== design/pwm_timer_period_planner_unit_assert.svh =====
// Assertion macros used by the checker file of the planner.
`ifndef PWM_TIMER_PERIOD_PLANNER_UNIT_ASSERT_SVH
`define PWM_TIMER_PERIOD_PLANNER_UNIT_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define PWMP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define PWMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/pwmp_pkg.sv =====
`default_nettype none
package pwmp_pkg;

    localparam int CLK_W      = 28;
    localparam int TCLK_W     = CLK_W + 1;
    localparam int VALUE_W    = 32;
    localparam int PROD_W     = VALUE_W + TCLK_W;
    localparam int CHAN_W     = 8;
    localparam int SLOT_W     = 2;
    localparam int PSC_W      = 16;
    localparam int IDX_W      = 3;
    localparam int DIV_STEP   = 4;
    localparam int RELOAD_BITS_DEFAULT = 16;

    localparam logic [PSC_W-1:0]  PSC_LIMIT = 16'hFFFF;
    localparam logic [SLOT_W-1:0] SLOT_MAX  = 2'd3;

    localparam logic [CLK_W-1:0] APB1_RESET  = 28'd42000000;
    localparam logic [CLK_W-1:0] APB2_RESET  = 28'd84000000;
    localparam logic [CLK_W-1:0] CORE_RESET  = 28'd168000000;
    localparam logic [CLK_W-1:0] RESOL_RESET = 28'd84000000;

    typedef enum logic [IDX_W-1:0] {
        REG_APB1_CLOCK  = 3'd0,
        REG_APB2_CLOCK  = 3'd1,
        REG_CORE_CLOCK  = 3'd2,
        REG_TIMER_APB2  = 3'd3,
        REG_RESOLUTION  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [TCLK_W-1:0] timer_clk;
        logic [CLK_W-1:0]  resolution;
    } cfg_t;

endpackage
`default_nettype wire

// ===== design/pwm_timer_period_planner_unit.sv =====
// PWM timer period planner. Each request transaction gives one result transaction, in
// order, and a new request is taken in every cycle while the result side does not stall.
// The pipeline has one register stage for the two 32 by 29 bit products, sixteen
// stages of the restoring divider that turns period and pulse into timer ticks at four
// quotient bits a stage, and eight stages of the divider that yields the reload value.
// The configuration registers may be written only while no request is in flight.
`default_nettype none
module pwm_timer_period_planner_unit #(
    parameter int RELOAD_BITS = pwmp_pkg::RELOAD_BITS_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [pwmp_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [pwmp_pkg::CLK_W-1:0] cfg_wdata,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [63:0]                s_axis_tdata,  // period, pulse
    input  wire logic [8:0]                 s_axis_tuser,  // channel, invert_polarity
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [63:0]                     m_axis_tdata,  // prescaler, reload, compare
    output logic [2:0]                      m_axis_tuser   // channel_slot, active_low
);
    import pwmp_pkg::*;

    localparam int TAG1_W = SLOT_W + 1;
    localparam int TAG2_W = SLOT_W + 1 + VALUE_W + PSC_W + 1;

    cfg_t cfg;

    pwmp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    logic              mul_valid_reg;
    logic [PROD_W-1:0] prod_reg [2];
    logic [TAG1_W-1:0] tag1_reg;
    logic              mul_ready;
    logic              div1_in_ready;
    logic [SLOT_W-1:0] slot;

    assign slot = (s_axis_tuser[7:0] > CHAN_W'(SLOT_MAX)) ? SLOT_MAX : s_axis_tuser[1:0];
    assign mul_ready = !mul_valid_reg || div1_in_ready;
    assign s_axis_tready = mul_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (mul_ready)
        begin
            mul_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_ready && s_axis_tvalid)
        begin
            prod_reg[0] <= PROD_W'(s_axis_tdata[31:0]) * PROD_W'(cfg.timer_clk);
            prod_reg[1] <= PROD_W'(s_axis_tdata[63:32]) * PROD_W'(cfg.timer_clk);
            tag1_reg    <= {s_axis_tuser[8], slot};
        end
    end

    logic               div1_valid;
    logic               div2_in_ready;
    logic [VALUE_W-1:0] ticks [2];
    logic [TAG1_W-1:0]  tag1_out;

    pwmp_div #(
        .DW    (PROD_W),
        .VW    (CLK_W),
        .QW    (VALUE_W),
        .LANES (2),
        .STEP  (DIV_STEP),
        .TAGW  (TAG1_W)
    ) u_conv (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (mul_valid_reg),
        .in_ready    (div1_in_ready),
        .in_dividend (prod_reg),
        .in_divisor  (cfg.resolution),
        .in_tag      (tag1_reg),
        .out_valid   (div1_valid),
        .out_ready   (div2_in_ready),
        .out_quot    (ticks),
        .out_tag     (tag1_out)
    );

    logic [VALUE_W-1:0] psc_full;
    logic               sat;
    logic [PSC_W-1:0]   psc;
    logic [PSC_W-1:0]   psc_div;
    logic [VALUE_W-1:0] div2_dividend [1];
    logic [TAG2_W-1:0]  tag2_in;

    assign psc_full = ticks[0] >> RELOAD_BITS;
    assign sat      = psc_full >= VALUE_W'(PSC_LIMIT);
    assign psc      = psc_full[PSC_W-1:0];
    assign psc_div  = sat ? PSC_W'(1) : psc + PSC_W'(1);
    assign div2_dividend[0] = ticks[0];
    assign tag2_in  = {sat, psc, ticks[1], tag1_out};

    logic [VALUE_W-1:0] eff [1];
    logic [TAG2_W-1:0]  tag2_out;
    logic [PSC_W-1:0]   reload;
    logic [PSC_W-1:0]   prescaler;
    logic [VALUE_W-1:0] eff_m1;

    pwmp_div #(
        .DW    (VALUE_W),
        .VW    (PSC_W),
        .QW    (VALUE_W),
        .LANES (1),
        .STEP  (DIV_STEP),
        .TAGW  (TAG2_W)
    ) u_reload (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (div1_valid),
        .in_ready    (div2_in_ready),
        .in_dividend (div2_dividend),
        .in_divisor  (psc_div),
        .in_tag      (tag2_in),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_quot    (eff),
        .out_tag     (tag2_out)
    );

    assign eff_m1    = (eff[0] == '0) ? '0 : eff[0] - VALUE_W'(1);
    assign prescaler = tag2_out[TAG2_W-1] ? PSC_LIMIT : tag2_out[TAG2_W-2 -: PSC_W];
    assign reload    = tag2_out[TAG2_W-1] ? PSC_LIMIT : eff_m1[PSC_W-1:0];

    assign m_axis_tdata = {tag2_out[TAG1_W +: VALUE_W], reload, prescaler};
    assign m_axis_tuser = tag2_out[TAG1_W-1:0];

endmodule
`default_nettype wire

// ===== design/pwmp_cfg.sv =====
`default_nettype none
module pwmp_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [pwmp_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [pwmp_pkg::CLK_W-1:0] cfg_wdata,
    output pwmp_pkg::cfg_t                  cfg
);
    import pwmp_pkg::*;

    logic [CLK_W-1:0] apb1_reg;
    logic [CLK_W-1:0] apb2_reg;
    logic [CLK_W-1:0] core_reg;
    logic             on_apb2_reg;
    logic [CLK_W-1:0] resol_reg;
    logic [CLK_W-1:0] bus;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apb1_reg    <= APB1_RESET;
            apb2_reg    <= APB2_RESET;
            core_reg    <= CORE_RESET;
            on_apb2_reg <= 1'b0;
            resol_reg   <= RESOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_APB1_CLOCK: apb1_reg    <= cfg_wdata;
                REG_APB2_CLOCK: apb2_reg    <= cfg_wdata;
                REG_CORE_CLOCK: core_reg    <= cfg_wdata;
                REG_TIMER_APB2: on_apb2_reg <= cfg_wdata[0];
                REG_RESOLUTION: resol_reg   <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // The timer clock runs at twice the bus clock when the bus is slower than the core.
    assign bus = on_apb2_reg ? apb2_reg : apb1_reg;
    assign cfg.timer_clk  = (bus < core_reg) ? {bus, 1'b0} : {1'b0, bus};
    assign cfg.resolution = resol_reg;

endmodule
`default_nettype wire

// ===== design/pwmp_div.sv =====
`default_nettype none
module pwmp_div #(
    parameter int DW    = 61,
    parameter int VW    = 28,
    parameter int QW    = 32,
    parameter int LANES = 1,
    parameter int STEP  = 4,
    parameter int TAGW  = 1
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [DW-1:0]   in_dividend [LANES],
    input  wire logic [VW-1:0]   in_divisor,
    input  wire logic [TAGW-1:0] in_tag,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [QW-1:0]        out_quot [LANES],
    output logic [TAGW-1:0]      out_tag
);
    import pwmp_pkg::*;

    localparam int STAGES = (DW + STEP - 1) / STEP;
    localparam int PW     = STAGES * STEP;

    logic            valid_reg   [STAGES];
    logic [VW-1:0]   divisor_reg [STAGES];
    logic [TAGW-1:0] tag_reg     [STAGES];
    logic [VW-1:0]   rem_reg     [STAGES][LANES];
    logic [PW-1:0]   dq_reg      [STAGES][LANES];
    logic            stage_ready [STAGES+1];

    // Restoring division: STEP quotient bits shifted into the low end of dq.
    function automatic logic [VW+PW-1:0] div_steps(input logic [VW-1:0] r,
                                                   input logic [PW-1:0] q,
                                                   input logic [VW-1:0] d);
        logic [VW:0]   t;
        logic [VW-1:0] rr;
        logic [PW-1:0] qq;
        rr = r;
        qq = q;
        for (int k = 0; k < STEP; k++)
        begin
            t  = {rr, qq[PW-1]};
            qq = {qq[PW-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t     = t - {1'b0, d};
                qq[0] = 1'b1;
            end
            rr = t[VW-1:0];
        end
        return {rr, qq};
    endfunction

    assign stage_ready[STAGES] = out_ready;
    assign in_ready = stage_ready[0];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic            src_valid;
        logic [VW-1:0]   src_div;
        logic [TAGW-1:0] src_tag;
        logic [VW-1:0]   src_rem [LANES];
        logic [PW-1:0]   src_dq  [LANES];

        if (s == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_div   = in_divisor;
            assign src_tag   = in_tag;
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign src_rem[l] = '0;
                assign src_dq[l]  = PW'(in_dividend[l]);
            end
        end
        else
        begin : g_next
            assign src_valid = valid_reg[s-1];
            assign src_div   = divisor_reg[s-1];
            assign src_tag   = tag_reg[s-1];
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign src_rem[l] = rem_reg[s-1][l];
                assign src_dq[l]  = dq_reg[s-1][l];
            end
        end

        assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (stage_ready[s])
            begin
                valid_reg[s] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[s] && src_valid)
            begin
                divisor_reg[s] <= src_div;
                tag_reg[s]     <= src_tag;
            end
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_calc
            logic [VW+PW-1:0] res;
            assign res = div_steps(src_rem[l], src_dq[l], src_div);

            always_ff @(posedge clk)
            begin
                if (stage_ready[s] && src_valid)
                begin
                    rem_reg[s][l] <= res[VW+PW-1:PW];
                    dq_reg[s][l]  <= res[PW-1:0];
                end
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];
    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign out_quot[l] = dq_reg[STAGES-1][l][QW-1:0];
    end

endmodule
`default_nettype wire

// ===== design/pwmp_checker.sv =====
`default_nettype none
`include "pwm_timer_period_planner_unit_assert.svh"
module pwmp_checker #(
    parameter int RELOAD_BITS = pwmp_pkg::RELOAD_BITS_DEFAULT
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);
    import pwmp_pkg::*;

    // A result that is not taken stays in place.
    `PWMP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // A saturated prescaler only ever comes with a saturated reload.
    `PWMP_ASSERT_SAME(a_sat_pair, m_axis_tvalid && m_axis_tdata[15:0] == PSC_LIMIT, m_axis_tdata[31:16] == PSC_LIMIT)

    // Without prescaling the scaled period fits the counter, so reload never saturates.
    `PWMP_ASSERT_SAME(a_no_psc, m_axis_tvalid && RELOAD_BITS <= PSC_W && m_axis_tdata[15:0] == '0, m_axis_tdata[31:16] != PSC_LIMIT)

endmodule

bind pwm_timer_period_planner_unit pwmp_checker #(.RELOAD_BITS(RELOAD_BITS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== dv/pwm_timer_period_planner_unit_checker.sv =====
`default_nettype none
module pwm_timer_period_planner_unit_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [pwmp_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [pwmp_pkg::CLK_W-1:0] cfg_wdata,
    input  wire logic                       s_tvalid,
    input  wire logic                       s_tready,
    input  wire logic [63:0]                s_tdata,
    input  wire logic [8:0]                 s_tuser,
    input  wire logic                       m_tvalid,
    input  wire logic                       m_tready,
    input  wire logic [63:0]                m_tdata,
    input  wire logic [2:0]                 m_tuser,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pwmp_pkg::*;

    typedef struct packed {
        logic [1:0]  slot;
        logic [15:0] psc;
        logic [15:0] rel;
        logic [31:0] cmp;
        logic        act_low;
    } plan_t;

    logic [CLK_W-1:0] apb1_hz, apb2_hz, core_hz, resol_hz;
    logic             on_apb2;
    plan_t            plan_q[$];

    function automatic logic [31:0] ticks_of(logic [31:0] cycles);
        logic [CLK_W-1:0] bus;
        logic [63:0]      tclk;
        logic [63:0]      prod;
        bus = on_apb2 ? apb2_hz : apb1_hz;
        tclk = (bus < core_hz) ? {35'd0, bus, 1'b0} : {36'd0, bus};
        prod = {32'd0, cycles} * tclk;
        if (resol_hz == '0)
            return 32'hFFFF_FFFF;
        return 32'(prod / {36'd0, resol_hz});
    endfunction

    function automatic plan_t plan_of(logic [7:0] chan, logic [31:0] per,
                                      logic [31:0] pul, logic inv);
        plan_t       r;
        logic [31:0] t;
        logic [31:0] p;
        logic [31:0] eff;
        t = ticks_of(per);
        p = t >> 16;
        r.slot = (chan > 8'd3) ? SLOT_MAX : chan[1:0];
        if (p >= 32'hFFFF)
        begin
            r.psc = PSC_LIMIT;
            r.rel = PSC_LIMIT;
        end
        else
        begin
            eff = t / (p + 32'd1);
            r.psc = p[15:0];
            r.rel = (eff > 0) ? 16'(eff - 32'd1) : 16'd0;
        end
        r.cmp = ticks_of(pul);
        r.act_low = inv;
        return r;
    endfunction

    assign pending = plan_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        plan_t got, want;
        if (!rst_n)
        begin
            apb1_hz  <= APB1_RESET;
            apb2_hz  <= APB2_RESET;
            core_hz  <= CORE_RESET;
            resol_hz <= RESOL_RESET;
            on_apb2  <= 1'b0;
            fail_count <= 0;
            plan_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                plan_q.push_back(plan_of(s_tuser[7:0], s_tdata[31:0], s_tdata[63:32],
                                         s_tuser[8]));
            if (m_tvalid && m_tready)
            begin
                got.psc = m_tdata[15:0];
                got.rel = m_tdata[31:16];
                got.cmp = m_tdata[63:32];
                got.slot = m_tuser[1:0];
                got.act_low = m_tuser[2];
                if (plan_q.size() == 0)
                begin
                    $display("%0t: expected no transaction, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = plan_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: expected slot %0d psc %h rel %h cmp %h low %b",
                                 $time, want.slot, want.psc, want.rel, want.cmp,
                                 want.act_low);
                        $display("%0t: actual   slot %0d psc %h rel %h cmp %h low %b",
                                 $time, got.slot, got.psc, got.rel, got.cmp, got.act_low);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_APB1_CLOCK: apb1_hz  <= cfg_wdata;
                    REG_APB2_CLOCK: apb2_hz  <= cfg_wdata;
                    REG_CORE_CLOCK: core_hz  <= cfg_wdata;
                    REG_TIMER_APB2: on_apb2  <= cfg_wdata[0];
                    REG_RESOLUTION: resol_hz <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== dv/tb_pwm_timer_period_planner_unit.sv =====
`default_nettype none
module tb_pwm_timer_period_planner_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import pwmp_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CLK_W-1:0] cfg_wdata;
    logic             s_tvalid, s_tready;
    logic [63:0]      s_tdata;
    logic [8:0]       s_tuser;
    logic             m_tvalid, m_tready;
    logic [63:0]      m_tdata;
    logic [2:0]       m_tuser;
    int               fail_count, pending;
    int               cycles;
    bit               calm;

    pwm_timer_period_planner_unit u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser), .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready), .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser)
    );

    pwm_timer_period_planner_unit_checker u_chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver stalls in bursts; none once the run is calm.
    initial
    begin
        int n;
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 5);
                m_tready = 1'b0;
                repeat (n) @(negedge clk);
                m_tready = 1'b1;
            end
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [CLK_W-1:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic send_request(logic [7:0] chan, logic [31:0] per, logic [31:0] pul,
                                logic inv);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {pul, per};
        s_tuser = {inv, chan};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 300);
            1: return $urandom_range(0, 70000);
            2: return $urandom_range(0, 5000000);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CLK_W-1:0] rand_clock();
        case ($urandom_range(0, 3))
            0: return CLK_W'($urandom_range(0, 3));
            1: return CLK_W'(28'hFFF_FFFF - $urandom_range(0, 3));
            2: return CLK_W'($urandom_range(1000000, 250000000));
            default: return CLK_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [31:0] edges[8];
        rst_n = 1'b0;
        calm = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        edges = '{0, 1, 65535, 65536, 131071, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 84000};
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < 8; i++)
            send_request(8'(i * 37), edges[i], edges[7 - i], i[0]);
        send_request(8'd3, 32'd4194304, 32'd100, 1'b1);
        send_request(8'd4, 32'd4294901760, 32'd0, 1'b0);
        send_request(8'd255, 32'd65535, 32'hFFFF_FFFF, 1'b1);
        drain();

        write_reg(REG_RESOLUTION, '0);
        send_request(8'd2, 32'd1000, 32'd5, 1'b0);
        drain();
        write_reg(REG_APB1_CLOCK, 28'hFFF_FFFF);
        write_reg(REG_APB2_CLOCK, 28'd1);
        write_reg(REG_CORE_CLOCK, 28'd0);
        write_reg(REG_TIMER_APB2, 28'd1);
        write_reg(REG_RESOLUTION, 28'd1);
        for (int i = 0; i < 4; i++)
            send_request(8'd1, edges[i + 3], edges[i], 1'b1);
        drain();
        write_reg(REG_TIMER_APB2, 28'd0);
        send_request(8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        drain();

        for (int ph = 0; ph < 13; ph++)
        begin
            write_reg(REG_APB1_CLOCK, rand_clock());
            write_reg(REG_APB2_CLOCK, rand_clock());
            write_reg(REG_CORE_CLOCK, rand_clock());
            write_reg(REG_TIMER_APB2, 28'($urandom_range(0, 1)));
            write_reg(REG_RESOLUTION, (ph == 5) ? 28'd0 : rand_clock());
            if (ph == 12)
                calm = 1'b1;
            for (int i = 0; i < 100; i++)
                send_request(8'($urandom), rand_value(), rand_value(), 1'($urandom));
            drain();
        end

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
